// ===== src/sab_pkg.sv =====
// ----------------------------------------------------------------------------
// Stack ALU package
// Shared widths, opcode and status codes, and divider request/response types.
// ----------------------------------------------------------------------------
package sab_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned OP_W    = 3;
  localparam int unsigned STS_W   = 2;

  localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
  localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
  localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
  localparam logic [OP_W-1:0] OP_DIV  = 3'd4;
  localparam logic [OP_W-1:0] OP_MOD  = 3'd5;

  localparam logic [STS_W-1:0] STS_OK      = 2'd0;
  localparam logic [STS_W-1:0] STS_SHORT   = 2'd1;
  localparam logic [STS_W-1:0] STS_DIVZERO = 2'd2;
  localparam logic [STS_W-1:0] STS_FULL    = 2'd3;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
    logic [DATA_W-1:0] remainder;
  } div_rsp_t;

endpackage

// ===== src/stack_alu_binary_ops.sv =====
// ----------------------------------------------------------------------------
// Stack ALU with binary operations
// Bounded stack of 32-bit signed integers with push, add, sub, mul, div, mod.
//
// Input stream: tuser carries the opcode, tdata the value to push. Every
// accepted transaction yields exactly one output transaction carrying the
// status in tuser and the top of stack and entry count in tdata.
// Push, errors and unused opcodes finish in the accept cycle.
// add, sub and mul read the second entry from the stack RAM (registered read)
// and finish in the next cycle.
// div and mod run through the radix-2 divider, one bit per cycle.
// The output register frees the input side: a new transaction is taken while
// a result waits, and if the receiver stalls a finished result is held in a
// status register until the output register is free, while the input stalls.
// The cached top of stack is the right operand; the RAM holds all entries.
// Reset empties the stack at once; RAM contents are not cleared.
// ----------------------------------------------------------------------------
module stack_alu_binary_ops
  import sab_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [DATA_W-1:0]   s_axis_tdata_i,  // push_value[31:0]
  input  logic [OP_W-1:0]     s_axis_tuser_i,  // opcode[2:0]
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [39:0]         m_axis_tdata_o,  // top_value[31:0], stack_count[38:32], zero
  output logic [STS_W-1:0]    m_axis_tuser_o   // status[1:0]
);

  localparam int unsigned PW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_HOLD = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [PW-1:0]      sp_q, sp_d;
  logic [DATA_W-1:0]  top_q, top_d;
  logic [OP_W-1:0]    op_q, op_d;
  logic [STS_W-1:0]   sts_q, sts_d;
  logic               m_valid_q, m_valid_d;
  logic [DATA_W-1:0]  out_top_q, out_top_d;
  logic [COUNT_W-1:0] out_cnt_q, out_cnt_d;
  logic [STS_W-1:0]   out_sts_q, out_sts_d;

  logic               s_fire;
  logic               out_free;
  logic               fin;
  logic [STS_W-1:0]   fin_sts;
  logic               load;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [DATA_W-1:0]  wdata;
  logic               re;
  logic [PW-1:0]      sp_below;
  logic [DATA_W-1:0]  left;
  logic [DATA_W-1:0]  alu_res;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign sp_below        = sp_q - PW'(2);

  sab_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (sp_below[AW-1:0]),
    .rdata_o (left)
  );

  sab_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    case (op_q)
      OP_ADD:  alu_res = left + top_q;
      OP_SUB:  alu_res = left - top_q;
      OP_MUL:  alu_res = left * top_q;
      default: alu_res = left + top_q;
    endcase
  end

  always_comb begin
    state_d          = state_q;
    sp_d             = sp_q;
    top_d            = top_q;
    op_d             = op_q;
    sts_d            = sts_q;
    fin              = 1'b0;
    fin_sts          = STS_OK;
    load             = 1'b0;
    we               = 1'b0;
    waddr            = sp_below[AW-1:0];
    wdata            = alu_res;
    re               = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = left;
    div_req.divisor  = top_q;

    case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          case (s_axis_tuser_i)
            OP_PUSH: begin
              fin = 1'b1;
              if (sp_q == PW'(STACK_DEPTH)) begin
                fin_sts = STS_FULL;
              end else begin
                we    = 1'b1;
                waddr = sp_q[AW-1:0];
                wdata = s_axis_tdata_i;
                sp_d  = sp_q + PW'(1);
                top_d = s_axis_tdata_i;
              end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
              if (sp_q < PW'(2)) begin
                fin     = 1'b1;
                fin_sts = STS_SHORT;
              end else if ((s_axis_tuser_i == OP_DIV || s_axis_tuser_i == OP_MOD)
                           && top_q == '0) begin
                fin     = 1'b1;
                fin_sts = STS_DIVZERO;
              end else begin
                re      = 1'b1;
                op_d    = s_axis_tuser_i;
                state_d = S_READ;
              end
            end
            default: fin = 1'b1;
          endcase
        end
      end
      S_READ: begin
        if (op_q == OP_DIV || op_q == OP_MOD) begin
          div_req.start = 1'b1;
          state_d       = S_DIV;
        end else begin
          fin   = 1'b1;
          we    = 1'b1;
          sp_d  = sp_q - PW'(1);
          top_d = alu_res;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          fin   = 1'b1;
          we    = 1'b1;
          wdata = (op_q == OP_DIV) ? div_rsp.quotient : div_rsp.remainder;
          sp_d  = sp_q - PW'(1);
          top_d = wdata;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          load    = 1'b1;
          fin_sts = sts_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (fin) begin
      if (out_free) begin
        load    = 1'b1;
        state_d = S_IDLE;
      end else begin
        sts_d   = fin_sts;
        state_d = S_HOLD;
      end
    end
  end

  always_comb begin
    m_valid_d = m_valid_q && !m_axis_tready_i;
    out_top_d = out_top_q;
    out_cnt_d = out_cnt_q;
    out_sts_d = out_sts_q;
    if (load) begin
      m_valid_d = 1'b1;
      out_sts_d = fin_sts;
      out_top_d = (sp_d != '0) ? top_d : '0;
      out_cnt_d = COUNT_W'(sp_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      sp_q      <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      sp_q      <= sp_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q     <= top_d;
    op_q      <= op_d;
    sts_q     <= sts_d;
    out_top_q <= out_top_d;
    out_cnt_q <= out_cnt_d;
    out_sts_q <= out_sts_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = out_sts_q;
  assign m_axis_tdata_o  = {1'b0, out_cnt_q, out_top_q};

`ifndef SYNTHESIS
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && s_axis_tuser_i == OP_PUSH && sp_q != PW'(STACK_DEPTH)
    |=> sp_q == $past(sp_q) + PW'(1))
    else $error("push did not grow the stack");

  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == S_DIV)
    else $error("divider finished outside its wait state");

  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> m_axis_tdata_o[38:32] == COUNT_W'(sp_q))
    else $error("reported count differs from stack pointer");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |-> sp_q >= PW'(2) && !s_axis_tready_o)
    else $error("operand read with a short stack");
`endif

endmodule

// ===== src/sab_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module sab_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/sab_divider.sv =====
// ----------------------------------------------------------------------------
// Stack ALU divider
// Signed radix-2 restoring divider, one quotient bit per cycle, truncating
// toward zero; the remainder takes the sign of the dividend.
// ----------------------------------------------------------------------------
module sab_divider
  import sab_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned CNT_W = $clog2(DATA_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DATA_W-1:0] quo_q, quo_d;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic [DATA_W-1:0] dsr_q, dsr_d;
  logic              neg_q_q, neg_q_d;
  logic              neg_r_q, neg_r_d;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic              fits;

  always_comb begin
    trial   = {rem_q, quo_q[DATA_W-1]};
    diff    = trial - {1'b0, dsr_q};
    fits    = trial >= {1'b0, dsr_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dsr_d   = dsr_q;
    neg_q_d = neg_q_q;
    neg_r_d = neg_r_q;
    if (req_i.start) begin
      busy_d  = 1'b1;
      cnt_d   = '0;
      rem_d   = '0;
      quo_d   = req_i.dividend[DATA_W-1] ? (DATA_W'(0) - req_i.dividend) : req_i.dividend;
      dsr_d   = req_i.divisor[DATA_W-1] ? (DATA_W'(0) - req_i.divisor) : req_i.divisor;
      neg_q_d = req_i.dividend[DATA_W-1] ^ req_i.divisor[DATA_W-1];
      neg_r_d = req_i.dividend[DATA_W-1];
    end else if (busy_q) begin
      rem_d = fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      quo_d = {quo_q[DATA_W-2:0], fits};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DATA_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    dsr_q   <= dsr_d;
    neg_q_q <= neg_q_d;
    neg_r_q <= neg_r_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = neg_q_q ? (DATA_W'(0) - quo_q) : quo_q;
  assign rsp_o.remainder = neg_r_q ? (DATA_W'(0) - rem_q) : rem_q;

endmodule

// ===== test/stack_alu_binary_ops_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack ALU binary operations testbench
// Drives push and arithmetic opcodes into the stack ALU and predicts each
// status, top of stack and entry count with a scoreboard of its own. A short
// directed sequence covers the short-stack, divide-by-zero and unused opcode
// cases and the wrap corners. Random traffic then fills, drains and churns
// the stack under four sender and receiver idle and stall phases.
// ----------------------------------------------------------------------------
module stack_alu_binary_ops_test;
  import sab_pkg::*;

  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned TAIL_CYCLES = 60;
  localparam logic signed [DATA_W-1:0] MOST_NEG = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] MOST_POS = 32'sh7fff_ffff;
  localparam logic [OP_W-1:0] OP_NOP6 = 3'd6;
  localparam logic [OP_W-1:0] OP_NOP7 = 3'd7;

  typedef struct packed {
    logic [STS_W-1:0]   status;
    logic [DATA_W-1:0]  top_value;
    logic [COUNT_W-1:0] stack_count;
  } stack_outcome_t;

  typedef enum logic [1:0] {
    MODE_MIXED,
    MODE_FILL,
    MODE_DRAIN
  } traffic_mode_e;

  class stack_scoreboard;
    logic [DATA_W-1:0] entries[STACK_DEPTH];
    int unsigned       depth;
    int unsigned       deepest;
    int unsigned       errors;
    int unsigned       compared;
    int unsigned       status_seen[4];
    stack_outcome_t    expected_outcomes[$];

    function void note_command(logic [OP_W-1:0] op, logic [DATA_W-1:0] value);
      logic [STS_W-1:0]         st;
      logic signed [DATA_W-1:0] lhs;
      logic signed [DATA_W-1:0] rhs;
      logic signed [DATA_W-1:0] res;
      stack_outcome_t           o;
      st = STS_OK;
      case (op)
        OP_PUSH: begin
          if (depth == STACK_DEPTH) begin
            st = STS_FULL;
          end else begin
            entries[depth] = value;
            depth++;
          end
        end
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
          if (depth < 2) begin
            st = STS_SHORT;
          end else begin
            rhs = entries[depth-1];
            lhs = entries[depth-2];
            if ((op == OP_DIV || op == OP_MOD) && rhs == 0) begin
              st = STS_DIVZERO;
            end else begin
              case (op)
                OP_ADD: res = lhs + rhs;
                OP_SUB: res = lhs - rhs;
                OP_MUL: res = lhs * rhs;
                OP_DIV: res = (lhs == MOST_NEG && rhs == -32'sd1) ? MOST_NEG : lhs / rhs;
                default: res = (lhs == MOST_NEG && rhs == -32'sd1) ? 32'sd0 : lhs % rhs;
              endcase
              entries[depth-2] = res;
              depth--;
            end
          end
        end
        default: ;
      endcase
      if (depth > deepest) deepest = depth;
      status_seen[st]++;
      o.status      = st;
      o.top_value   = (depth != 0) ? entries[depth-1] : '0;
      o.stack_count = COUNT_W'(depth);
      expected_outcomes.push_back(o);
    endfunction

    function void check_result(logic [STS_W-1:0] st, logic [39:0] data);
      stack_outcome_t exp_o;
      if (expected_outcomes.size() == 0) begin
        $error("result with nothing expected: status %0d, tdata %h", st, data);
        errors++;
        return;
      end
      exp_o = expected_outcomes.pop_front();
      compared++;
      if (st !== exp_o.status) begin
        $error("status: expected %0d, actual %0d", exp_o.status, st);
        errors++;
      end
      if (data[31:0] !== exp_o.top_value) begin
        $error("top_value: expected %h, actual %h", exp_o.top_value, data[31:0]);
        errors++;
      end
      if (data[38:32] !== exp_o.stack_count) begin
        $error("stack_count: expected %0d, actual %0d", exp_o.stack_count, data[38:32]);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [DATA_W-1:0]   s_axis_tdata;
  logic [OP_W-1:0]     s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [39:0]         m_axis_tdata;
  logic [STS_W-1:0]    m_axis_tuser;

  stack_scoreboard sb;
  int unsigned     idle_pct;
  int unsigned     stall_pct;
  int unsigned     cycle_count;
  int unsigned     sent_total;

  stack_alu_binary_ops #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tuser, m_axis_tdata);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_command(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_command(op, value);
    sent_total++;
  endtask

  // hold the sender off until every outstanding result is back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_outcomes.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return MOST_NEG;
      1: return MOST_POS;
      2: return '0;
      3: return '1;
      4: return 32'd1;
      5, 6: return $urandom_range(16) - 32'd8;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_opcode(int unsigned push_pct);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 2) return OP_W'($urandom_range(7, 6));
    if (roll < push_pct + 2) return OP_PUSH;
    return OP_W'($urandom_range(5, 1));
  endfunction

  task automatic run_random(input int unsigned n_items);
    traffic_mode_e mode;
    int unsigned   linger;
    int unsigned   sent;
    int unsigned   push_pct;
    logic          settled;
    logic [OP_W-1:0] op;
    mode   = MODE_MIXED;
    linger = $urandom_range(60, 20);
    sent   = 0;
    while (sent < n_items) begin
      case (mode)
        MODE_FILL:  settled = (sb.depth == STACK_DEPTH);
        MODE_DRAIN: settled = (sb.depth < 2);
        default:    settled = 1'b1;
      endcase
      if (settled) begin
        if (linger == 0) begin
          case ($urandom_range(2))
            0: mode = MODE_FILL;
            1: mode = MODE_DRAIN;
            default: mode = MODE_MIXED;
          endcase
          linger = (mode == MODE_MIXED) ? $urandom_range(120, 40) : $urandom_range(8, 2);
        end else begin
          linger--;
        end
      end
      case (mode)
        MODE_FILL:  push_pct = 80;
        MODE_DRAIN: push_pct = 15;
        default:    push_pct = 50;
      endcase
      op = pick_opcode(push_pct);
      send_command(op, pick_value());
      if (op <= OP_MOD) sent++;
    end
  endtask

  initial begin
    sb            = new();
    idle_pct      = 0;
    stall_pct     = 0;
    sent_total    = 0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_PUSH;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_command(OP_ADD,  '0);
    send_command(OP_PUSH, 32'd7);
    send_command(OP_MUL,  '1);
    send_command(OP_PUSH, '0);
    send_command(OP_DIV,  '0);
    send_command(OP_MOD,  '0);
    send_command(OP_NOP6, '1);
    send_command(OP_NOP7, 32'h5a5a_a5a5);
    send_command(OP_ADD,  '0);
    send_command(OP_PUSH, -32'sd2);
    send_command(OP_DIV,  '0);
    send_command(OP_PUSH, 32'd2);
    send_command(OP_MOD,  '0);
    send_command(OP_PUSH, MOST_NEG);
    send_command(OP_PUSH, '1);
    send_command(OP_DIV,  '0);
    send_command(OP_PUSH, '1);
    send_command(OP_MOD,  '0);
    send_command(OP_PUSH, MOST_POS);
    send_command(OP_PUSH, 32'd1);
    send_command(OP_ADD,  '0);
    send_command(OP_PUSH, 32'd1);
    send_command(OP_SUB,  '0);
    send_command(OP_PUSH, MOST_POS);
    send_command(OP_MUL,  '0);
    drain_results();

    run_random(480);
    drain_results();
    idle_pct = 87;
    run_random(480);
    drain_results();
    idle_pct  = 0;
    stall_pct = 87;
    run_random(480);
    drain_results();
    idle_pct  = 25;
    stall_pct = 25;
    run_random(480);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.expected_outcomes.size() != 0) begin
      $error("%0d results never arrived", sb.expected_outcomes.size());
      sb.errors++;
    end
    $display("Sent %0d transactions over four idle/stall phases, %0d results compared.",
             sent_total, sb.compared);
    $display("Status ok %0d, too short %0d, divide by zero %0d, full %0d; deepest stack %0d.",
             sb.status_seen[STS_OK], sb.status_seen[STS_SHORT],
             sb.status_seen[STS_DIVZERO], sb.status_seen[STS_FULL], sb.deepest);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
